@@ rtl/core/tcf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tcf_pkg;

  // sample and result widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int DATA_W       = 16;
  localparam int COEF_W       = 15;
  localparam int STATE_W      = 32;

  // cordic sizing
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int ATAN_DEPTH   = 24;
  localparam int ATAN_AW      = $clog2(ATAN_DEPTH);
  localparam int CORDIC_W     = SAMPLE_WIDTH + 4;
  localparam int ANGLE_W      = 24;
  localparam int HALF_PI_Q20  = 1647099;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED = 2'd2;

  // register reset values
  localparam logic [COEF_W-1:0] BLEND_RESET = 15'd32440;
  localparam logic [COEF_W-1:0] GAIN_RESET  = 15'd130;
  localparam logic [COEF_W-1:0] SPEED_RESET = 15'd31457;

  // arctangent of 2^-i at 2^-20 rad, rounded
  localparam logic [20:0] ATAN_Q20 [ATAN_DEPTH] = '{
    21'd823550, 21'd486170, 21'd256879, 21'd130396, 21'd65451, 21'd32757,
    21'd16383,  21'd8192,   21'd4096,   21'd2048,   21'd1024,  21'd512,
    21'd256,    21'd128,    21'd64,     21'd32,     21'd16,    21'd8,
    21'd4,      21'd2,      21'd1,      21'd0,      21'd0,     21'd0
  };

  // filter coefficients shared with the datapath
  typedef struct packed {
    logic [COEF_W-1:0] blend;
    logic [COEF_W-1:0] gain;
    logic [COEF_W-1:0] speed;
  } tcf_coef_t;

endpackage

`default_nettype wire

@@ rtl/core/tcf_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// imu sample channel
interface tcf_sample_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [tcf_pkg::SAMPLE_WIDTH-1:0]  accel_gravity;
  logic signed [tcf_pkg::SAMPLE_WIDTH-1:0]  accel_down;
  logic signed [tcf_pkg::DATA_W-1:0]        rot_rate;

  modport source (output valid, accel_gravity, accel_down, rot_rate, input ready);
  modport sink   (input valid, accel_gravity, accel_down, rot_rate, output ready);
endinterface

// fused angle channel
interface tcf_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [tcf_pkg::DATA_W-1:0]  tilt_angle;
  logic signed [tcf_pkg::DATA_W-1:0]  filtered_rate;

  modport source (output valid, tilt_angle, filtered_rate, input ready);
  modport sink   (input valid, tilt_angle, filtered_rate, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tcf_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tcf_cordic (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    start,
  input  wire logic signed [tcf_pkg::SAMPLE_WIDTH-1:0] gravity,
  input  wire logic signed [tcf_pkg::SAMPLE_WIDTH-1:0] down,
  output logic                                         done,
  output logic signed [tcf_pkg::DATA_W-1:0]            tilt
);

  localparam int CW = tcf_pkg::CORDIC_W;
  localparam int ZW = tcf_pkg::ANGLE_W;
  localparam logic [tcf_pkg::STEP_W-1:0] LAST_STEP =
    tcf_pkg::STEP_W'(tcf_pkg::CORDIC_STEPS - 1);
  localparam logic signed [ZW-1:0] HALF_PI = signed'(ZW'(tcf_pkg::HALF_PI_Q20));
  localparam logic signed [ZW-1:0] Z_HALF  = signed'(ZW'(128));

  logic                             busy;
  logic [tcf_pkg::STEP_W-1:0]       step;
  logic signed [CW-1:0]             x;
  logic signed [CW-1:0]             y;
  logic signed [ZW-1:0]             z;
  logic                             zero_vec;

  logic signed [CW-1:0]             x0;
  logic signed [CW-1:0]             y0;
  logic signed [CW-1:0]             dx;
  logic signed [CW-1:0]             dy;
  logic signed [ZW-1:0]             atan_step;
  logic signed [ZW-1:0]             z_rnd;

  // vector is (-down, gravity)
  assign x0 = -CW'(down);
  assign y0 = CW'(gravity);

  // shared shift-add unit, one micro-rotation per cycle
  assign dx        = y >>> step;
  assign dy        = x >>> step;
  assign atan_step = signed'(ZW'(tcf_pkg::ATAN_Q20[tcf_pkg::ATAN_AW'(step)]));

  // round to q3.12 and negate
  assign z_rnd = (z + Z_HALF) >>> 8;
  assign tilt  = zero_vec ? '0 : -tcf_pkg::DATA_W'(z_rnd);

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  // vector and angle datapath
  always_ff @(posedge clk) begin
    if (start) begin
      zero_vec <= (x0 == '0) && (y0 == '0);
      if (x0[CW-1]) begin
        // left half plane: turn by a quarter first
        if (!y0[CW-1]) begin
          x <= y0;
          y <= -x0;
          z <= HALF_PI;
        end else begin
          x <= -y0;
          y <= x0;
          z <= -HALF_PI;
        end
      end else begin
        x <= x0;
        y <= y0;
        z <= '0;
      end
    end else if (busy) begin
      if (!y[CW-1]) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_step;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_step;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tcf_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tcf_filter (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [tcf_pkg::DATA_W-1:0]  tilt,
  input  wire logic signed [tcf_pkg::DATA_W-1:0]  rate,
  input  wire tcf_pkg::tcf_coef_t                 coef,
  output logic                                    done,
  output logic signed [tcf_pkg::DATA_W-1:0]       angle,
  output logic signed [tcf_pkg::DATA_W-1:0]       speed
);

  localparam int SW    = tcf_pkg::STATE_W;
  localparam int DW    = tcf_pkg::DATA_W;
  localparam int CF_W  = tcf_pkg::COEF_W + 2;
  localparam int ACC_W = 48;
  localparam int PRD_W = CF_W + SW;
  localparam int SUM_W = SW + 2;

  localparam logic signed [ACC_W-1:0] ACC_HALF = signed'(ACC_W'(16384));
  localparam logic signed [ACC_W-1:0] ST_MAX   = signed'(ACC_W'(2147483647));
  localparam logic signed [ACC_W-1:0] ST_MIN   = -ST_MAX - signed'(ACC_W'(1));
  localparam logic signed [SUM_W-1:0] OUT_MAX  = signed'(SUM_W'(32767));
  localparam logic signed [SUM_W-1:0] OUT_MIN  = -signed'(SUM_W'(32768));
  localparam logic [CF_W-1:0]         COEF_ONE = CF_W'(32768);

  // filter select codes
  localparam logic [1:0] FILT_ACCEL = 2'd0;
  localparam logic [1:0] FILT_GYRO  = 2'd1;
  localparam logic [1:0] FILT_RATE  = 2'd2;

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_MULS  = 5'b00010,
    F_MULD  = 5'b00100,
    F_WRITE = 5'b01000,
    F_OUT   = 5'b10000
  } fstate_t;

  fstate_t                   fstate;
  logic [1:0]                sel;
  logic signed [SW-1:0]      st_accel;
  logic signed [SW-1:0]      st_gyro;
  logic signed [SW-1:0]      st_rate;
  logic signed [ACC_W-1:0]   acc;
  logic signed [DW-1:0]      tilt_r;
  logic signed [DW-1:0]      rate_r;

  logic signed [SW-1:0]      s_cur;
  logic [tcf_pkg::COEF_W-1:0] pole_cur;
  logic [CF_W-1:0]           drive_coef;
  logic signed [DW-1:0]      drive_in;
  logic signed [CF_W-1:0]    mul_a;
  logic signed [SW-1:0]      mul_b;
  logic signed [PRD_W-1:0]   prod;
  logic signed [ACC_W-1:0]   prod_w;
  logic signed [ACC_W-1:0]   drive_term;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [SW-1:0]      st_new;
  logic signed [SUM_W-1:0]   ang_sum;
  logic signed [SUM_W-1:0]   spd_sum;

  // operand selection for the current filter
  always_comb begin
    case (sel)
      FILT_ACCEL: begin
        s_cur      = st_accel;
        pole_cur   = coef.blend;
        drive_coef = COEF_ONE - CF_W'(coef.blend);
        drive_in   = tilt_r;
      end
      FILT_GYRO: begin
        s_cur      = st_gyro;
        pole_cur   = coef.blend;
        drive_coef = CF_W'(coef.gain);
        drive_in   = rate_r;
      end
      default: begin
        s_cur      = st_rate;
        pole_cur   = coef.speed;
        drive_coef = COEF_ONE - CF_W'(coef.speed);
        drive_in   = rate_r;
      end
    endcase
  end

  // shared multiplier: pole times state, then coefficient times drive
  assign mul_a  = (fstate == F_MULS) ? signed'(CF_W'(pole_cur)) : signed'(drive_coef);
  assign mul_b  = (fstate == F_MULS) ? s_cur : SW'(drive_in);
  assign prod   = mul_a * mul_b;
  assign prod_w = signed'(prod[ACC_W-1:0]);
  // angle drive is aligned by 2^12, rate drive by 2^13
  assign drive_term = (sel == FILT_ACCEL) ? (prod_w <<< 12) : (prod_w <<< 13);

  // round half up and clamp to 32 bits
  assign acc_rnd = (acc + ACC_HALF) >>> 15;
  always_comb begin
    if (acc_rnd > ST_MAX) begin
      st_new = SW'(ST_MAX);
    end else if (acc_rnd < ST_MIN) begin
      st_new = SW'(ST_MIN);
    end else begin
      st_new = SW'(acc_rnd);
    end
  end

  // output rounding
  assign ang_sum = (SUM_W'(st_accel) + SUM_W'(st_gyro) + signed'(SUM_W'(2048))) >>> 12;
  assign spd_sum = (SUM_W'(st_rate) + signed'(SUM_W'(4096))) >>> 13;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      fstate   <= F_IDLE;
      sel      <= FILT_ACCEL;
      done     <= 1'b0;
      st_accel <= '0;
      st_gyro  <= '0;
      st_rate  <= '0;
    end else begin
      done <= 1'b0;
      unique case (fstate)
        F_IDLE: begin
          if (start) begin
            sel    <= FILT_ACCEL;
            fstate <= F_MULS;
          end
        end
        F_MULS: begin
          fstate <= F_MULD;
        end
        F_MULD: begin
          fstate <= F_WRITE;
        end
        F_WRITE: begin
          case (sel)
            FILT_ACCEL: st_accel <= st_new;
            FILT_GYRO:  st_gyro  <= st_new;
            default:    st_rate  <= st_new;
          endcase
          if (sel == FILT_RATE) begin
            fstate <= F_OUT;
          end else begin
            sel    <= sel + 1'b1;
            fstate <= F_MULS;
          end
        end
        F_OUT: begin
          done   <= 1'b1;
          fstate <= F_IDLE;
        end
        default: begin
          fstate <= F_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start && (fstate == F_IDLE)) begin
      tilt_r <= tilt;
      rate_r <= rate;
    end
    if (fstate == F_MULS) begin
      acc <= prod_w;
    end else if (fstate == F_MULD) begin
      acc <= acc + drive_term;
    end
    if (fstate == F_OUT) begin
      if (ang_sum > OUT_MAX) begin
        angle <= DW'(OUT_MAX);
      end else if (ang_sum < OUT_MIN) begin
        angle <= DW'(OUT_MIN);
      end else begin
        angle <= DW'(ang_sum);
      end
      if (spd_sum > OUT_MAX) begin
        speed <= DW'(OUT_MAX);
      end else if (spd_sum < OUT_MIN) begin
        speed <= DW'(OUT_MIN);
      end else begin
        speed <= DW'(spd_sum);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tilt_complementary_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  payload                                  handshake
// sample    in   accel_gravity, accel_down, rot_rate      valid / ready
// result    out  tilt_angle, filtered_rate                valid / ready
// cfg       in   cfg_index, cfg_data                      cfg_we
//
// a word goes from acceptance to a valid result through 16 cordic
// micro-rotations on one shift-add unit, then 3 filters, each a multiply,
// multiply and write on one shared 17x32 multiplier, plus load and output.
// the next sample is accepted once the result is in the output register.
// reset is synchronous and restores the default coefficients and clears
// all filter state; a stalled result holds the core until it can be stored.

module tilt_complementary_filter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  tcf_sample_if.sink                             sample,
  tcf_result_if.source                           result,
  input  wire logic                              cfg_we,
  input  wire logic [tcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tcf_pkg::COEF_W-1:0]        cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CORDIC = 4'b0010,
    ST_FILTER = 4'b0100,
    ST_HOLD   = 4'b1000
  } state_t;

  state_t                                state;
  tcf_pkg::tcf_coef_t                    coef;
  logic signed [tcf_pkg::DATA_W-1:0]     rate_r;

  logic                                  accept;
  logic                                  cordic_done;
  logic signed [tcf_pkg::DATA_W-1:0]     cordic_tilt;
  logic                                  filt_done;
  logic signed [tcf_pkg::DATA_W-1:0]     filt_angle;
  logic signed [tcf_pkg::DATA_W-1:0]     filt_speed;
  logic                                  out_free;
  logic                                  out_load;

  assign sample.ready = (state == ST_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign out_free     = !result.valid || result.ready;
  assign out_load     = out_free && (filt_done || (state == ST_HOLD));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.blend <= tcf_pkg::BLEND_RESET;
      coef.gain  <= tcf_pkg::GAIN_RESET;
      coef.speed <= tcf_pkg::SPEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcf_pkg::REG_BLEND: coef.blend <= cfg_data;
        tcf_pkg::REG_GAIN:  coef.gain  <= cfg_data;
        tcf_pkg::REG_SPEED: coef.speed <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the gyro rate for the filter pass
  always_ff @(posedge clk) begin
    if (accept) begin
      rate_r <= sample.rot_rate;
    end
  end

  tcf_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .gravity (sample.accel_gravity),
    .down    (sample.accel_down),
    .done    (cordic_done),
    .tilt    (cordic_tilt)
  );

  tcf_filter u_filter (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_done),
    .tilt  (cordic_tilt),
    .rate  (rate_r),
    .coef  (coef),
    .done  (filt_done),
    .angle (filt_angle),
    .speed (filt_speed)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CORDIC;
          end
        end
        ST_CORDIC: begin
          if (cordic_done) begin
            state <= ST_FILTER;
          end
        end
        ST_FILTER: begin
          if (filt_done) begin
            state <= out_free ? ST_IDLE : ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.tilt_angle    <= filt_angle;
      result.filtered_rate <= filt_speed;
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst) accept |=> !sample.ready)
    else $error("sample taken while core busy");

  assert property (@(posedge clk) disable iff (rst) cordic_done |-> state == ST_CORDIC)
    else $error("cordic finished outside its phase");

  assert property (@(posedge clk) disable iff (rst) filt_done |-> state == ST_FILTER)
    else $error("filter finished outside its phase");

  assert property (@(posedge clk) disable iff (rst) (state == ST_HOLD) |-> result.valid)
    else $error("result held while output register empty");

endmodule

`default_nettype wire
